// ===== hdl/tcpq_pkg.sv =====
package tcpq_pkg;

    // fixed field widths
    localparam int TAG_WIDTH = 16;
    localparam int BYTES_W   = 16;
    localparam int QLIM_W    = 7;
    localparam int LIMB_W    = QLIM_W + BYTES_W;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // defaults for the top level parameter
    localparam int DEF_QUEUE_DEPTH = 64;

    // drops taken by one shrink before it yields
    localparam int MAX_RESULTS = 64;

    // is_ack value that marks an acknowledgement
    localparam logic PT_ACK = 1'b1;

    // opcodes
    localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
    localparam logic [OP_W-1:0] OP_SHRINK = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROP    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TWO_QUEUE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_FRONT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QLIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_SIZE  = 3'd4;

    // register reset values
    localparam logic               RST_TWO_QUEUE  = 1'b1;
    localparam logic               RST_BYTE_MODE  = 1'b0;
    localparam logic               RST_DROP_FRONT = 1'b0;
    localparam logic [QLIM_W-1:0]  RST_QLIMIT     = 7'd50;
    localparam logic [BYTES_W-1:0] RST_MEAN_SIZE  = 16'd500;
    localparam logic [LIMB_W-1:0]  RST_LIMIT_BYTES = LIMB_W'(50 * 500);

    typedef struct packed {
        logic               two_queue_enable;
        logic               byte_mode;
        logic               drop_front;
        logic [QLIM_W-1:0]  queue_limit;
        logic [BYTES_W-1:0] mean_packet_size;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;     // capture input beat
        logic              rd;       // read one FIFO entry
        logic              rd_high;  // read from high FIFO
        logic              rd_tail;  // read tail instead of head
        logic              push;     // append arrival to its FIFO
        logic              pop;      // remove the entry last read
        logic              emit;     // load output register
        logic              use_rd;   // result payload from read entry
        logic              last;
        logic [KIND_W-1:0] kind;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            arr_high;    // arrival bound for high FIFO
        logic            arr_over;    // arrival hits the limit
        logic            arr_full;    // arrival FIFO physically full
        logic            arr_empty;   // arrival FIFO empty
        logic            deq_high;    // dequeue serves high FIFO
        logic            lo_nonempty;
        logic            shrink_go;   // total above limit and not empty
        logic            shrink_last; // current drop ends the shrink
        logic            drop_front;
        logic            out_free;
    } dp_stat_t;

endpackage

// ===== hdl/two_class_priority_drop_tail_queue_unit.sv =====
// Channel | Direction | Handshake             | Beat
// in      | inbound   | in_valid / in_stall   | opcode, packet_tag, packet_bytes, is_ack
// out     | outbound  | out_valid / out_stall | result_kind, out_tag, out_bytes, from_high, last
// cfg     | inbound   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item in flight. Enqueue without a head drop and the kind-0 cases emit their
// result from the decide state; dequeue and drop-front enqueue add a pop state after the
// registered FIFO read. Shrink runs the read-then-update loop on the FIFO read port, a
// decide and a pop per dropped packet; at most 64 drops per shrink.
// Reset clears pointers, counts and byte total and loads the register reset values; no clearing pass.
// A result waiting under out_stall holds the unit in its emitting state; a new item is
// still taken while the last result of the previous one waits.
module two_class_priority_drop_tail_queue_unit #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcpq_pkg::OP_W-1:0]         opcode,
    input  logic [tcpq_pkg::TAG_WIDTH-1:0]    packet_tag,
    input  logic [tcpq_pkg::BYTES_W-1:0]      packet_bytes,
    input  logic                              is_ack,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcpq_pkg::KIND_W-1:0]       result_kind,
    output logic [tcpq_pkg::TAG_WIDTH-1:0]    out_tag,
    output logic [tcpq_pkg::BYTES_W-1:0]      out_bytes,
    output logic                              from_high,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcpq_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import tcpq_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic [LIMB_W-1:0] limit_bytes_reg, limit_bytes_next;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    // register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TWO_QUEUE:  cfg_next.two_queue_enable = cfg_data[0];
                REG_BYTE_MODE:  cfg_next.byte_mode        = cfg_data[0];
                REG_DROP_FRONT: cfg_next.drop_front       = cfg_data[0];
                REG_QLIMIT:     cfg_next.queue_limit      = cfg_data[QLIM_W-1:0];
                REG_MEAN_SIZE:  cfg_next.mean_packet_size = cfg_data[BYTES_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // byte limit, registered from the registers, so it follows them in the cycle after
    assign limit_bytes_next = LIMB_W'(cfg_reg.queue_limit) * LIMB_W'(cfg_reg.mean_packet_size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.two_queue_enable <= RST_TWO_QUEUE;
            cfg_reg.byte_mode        <= RST_BYTE_MODE;
            cfg_reg.drop_front       <= RST_DROP_FRONT;
            cfg_reg.queue_limit      <= RST_QLIMIT;
            cfg_reg.mean_packet_size <= RST_MEAN_SIZE;
            limit_bytes_reg          <= RST_LIMIT_BYTES;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            limit_bytes_reg <= limit_bytes_next;
        end
    end

    tcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .limit_bytes  (limit_bytes_reg),
        .opcode       (opcode),
        .packet_tag   (packet_tag),
        .packet_bytes (packet_bytes),
        .is_ack       (is_ack),
        .cmd          (cmd),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .out_tag      (out_tag),
        .out_bytes    (out_bytes),
        .from_high    (from_high),
        .last         (last)
    );

endmodule

// ===== hdl/tcpq_ctrl.sv =====
module tcpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tcpq_pkg::dp_stat_t stat,
    output tcpq_pkg::dp_cmd_t  cmd
);
    import tcpq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_POP    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.op)
                    OP_ENQ:
                    begin
                        if (stat.arr_over && stat.drop_front && !stat.arr_empty)
                        begin
                            // fetch head to be dropped, arrival appended at pop
                            cmd.rd      = 1'b1;
                            cmd.rd_high = stat.arr_high;
                            state_next  = S_POP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                            if (stat.arr_over || stat.arr_full)
                            begin
                                cmd.kind = KIND_DROP;
                            end
                            else
                            begin
                                cmd.kind = KIND_ACCEPT;
                                cmd.push = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (stat.deq_high || stat.lo_nonempty)
                        begin
                            cmd.rd      = 1'b1;
                            cmd.rd_high = stat.deq_high;
                            state_next  = S_POP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.kind   = KIND_NONE;
                            state_next = S_IDLE;
                        end
                    end
                    OP_SHRINK:
                    begin
                        if (stat.shrink_go)
                        begin
                            // low FIFO first, high only once low is empty
                            cmd.rd      = 1'b1;
                            cmd.rd_high = !stat.lo_nonempty;
                            cmd.rd_tail = !stat.drop_front;
                            state_next  = S_POP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.kind   = KIND_NONE;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.kind   = KIND_NONE;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.pop    = 1'b1;
                    cmd.push   = (stat.op == OP_ENQ);
                    cmd.emit   = 1'b1;
                    cmd.use_rd = 1'b1;
                    cmd.kind   = (stat.op == OP_DEQ) ? KIND_DELIVER : KIND_DROP;
                    cmd.last   = (stat.op == OP_SHRINK) ? stat.shrink_last : 1'b1;
                    state_next = cmd.last ? S_IDLE : S_DECIDE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // pop state only follows a memory read
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) && !$past(state_reg == S_POP) |-> $past(cmd.rd))
        else $error("pop state entered without a read");

    // a result beat never overwrites one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted into a busy output register");

endmodule

// ===== hdl/tcpq_datapath.sv =====
module tcpq_datapath #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcpq_pkg::cfg_t                   cfg,
    input  logic [tcpq_pkg::LIMB_W-1:0]      limit_bytes,
    input  logic [tcpq_pkg::OP_W-1:0]        opcode,
    input  logic [tcpq_pkg::TAG_WIDTH-1:0]   packet_tag,
    input  logic [tcpq_pkg::BYTES_W-1:0]     packet_bytes,
    input  logic                             is_ack,
    input  tcpq_pkg::dp_cmd_t                cmd,
    output tcpq_pkg::dp_stat_t               stat,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [tcpq_pkg::KIND_W-1:0]      result_kind,
    output logic [tcpq_pkg::TAG_WIDTH-1:0]   out_tag,
    output logic [tcpq_pkg::BYTES_W-1:0]     out_bytes,
    output logic                             from_high,
    output logic                             last
);
    import tcpq_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W  = CNT_W + 1;
    localparam int BT_W   = BYTES_W + $clog2(2 * QUEUE_DEPTH);
    localparam int BC_W   = ((BT_W > LIMB_W) ? BT_W : LIMB_W) + 1;
    localparam int PC_W   = ((TOT_W > QLIM_W) ? TOT_W : QLIM_W) + 1;
    localparam int ENT_W  = TAG_WIDTH + BYTES_W;
    localparam int NCNT_W = $clog2(MAX_RESULTS);

    localparam logic [PTR_W:0]  DEPTH_X  = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // pointer sum below twice the depth folded back into range
    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] x);
        logic [PTR_W:0] y;
        y = (x >= DEPTH_X) ? (x - DEPTH_X) : x;
        return y[PTR_W-1:0];
    endfunction

    // descriptor stores
    logic [ENT_W-1:0] hi_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] lo_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] hi_rdata_reg;
    logic [ENT_W-1:0] lo_rdata_reg;

    // current item
    logic [OP_W-1:0]      op_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic                 hi_reg;

    // queue state
    logic [PTR_W-1:0]  hi_head_reg, hi_head_next;
    logic [PTR_W-1:0]  lo_head_reg, lo_head_next;
    logic [CNT_W-1:0]  hi_cnt_reg,  hi_cnt_next;
    logic [CNT_W-1:0]  lo_cnt_reg,  lo_cnt_next;
    logic [BT_W-1:0]   byte_total_reg, byte_total_next;
    logic [NCNT_W-1:0] drop_cnt_reg, drop_cnt_next;
    logic              rd_high_reg;
    logic              rd_tail_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [TAG_WIDTH-1:0] otag_reg;
    logic [BYTES_W-1:0]   obytes_reg;
    logic                 ohigh_reg;
    logic                 olast_reg;

    logic [PTR_W-1:0]   hi_wslot, lo_wslot, hi_tslot, lo_tslot;
    logic [PTR_W-1:0]   hi_raddr, lo_raddr;
    logic [ENT_W-1:0]   rd_entry;
    logic [BYTES_W-1:0] rd_bytes;
    logic [CNT_W-1:0]   arr_cnt;
    logic [TOT_W-1:0]   total, total_after;
    logic [BT_W-1:0]    bytes_after;
    logic               over_after;
    logic               out_free;

    // slot arithmetic
    assign hi_wslot = wrap((PTR_W + 1)'(hi_head_reg) + (PTR_W + 1)'(hi_cnt_reg));
    assign lo_wslot = wrap((PTR_W + 1)'(lo_head_reg) + (PTR_W + 1)'(lo_cnt_reg));
    assign hi_tslot = wrap((PTR_W + 1)'(hi_head_reg) + (PTR_W + 1)'(hi_cnt_reg)
                           - (PTR_W + 1)'(1));
    assign lo_tslot = wrap((PTR_W + 1)'(lo_head_reg) + (PTR_W + 1)'(lo_cnt_reg)
                           - (PTR_W + 1)'(1));
    assign hi_raddr = cmd.rd_tail ? hi_tslot : hi_head_reg;
    assign lo_raddr = cmd.rd_tail ? lo_tslot : lo_head_reg;

    // memory ports: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.push && hi_reg)
        begin
            hi_mem[hi_wslot] <= {tag_reg, bytes_reg};
        end
        if (cmd.rd && cmd.rd_high)
        begin
            hi_rdata_reg <= hi_mem[hi_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && !hi_reg)
        begin
            lo_mem[lo_wslot] <= {tag_reg, bytes_reg};
        end
        if (cmd.rd && !cmd.rd_high)
        begin
            lo_rdata_reg <= lo_mem[lo_raddr];
        end
    end

    assign rd_entry = rd_high_reg ? hi_rdata_reg : lo_rdata_reg;
    assign rd_bytes = rd_entry[BYTES_W-1:0];

    // status toward the controller
    assign arr_cnt     = hi_reg ? hi_cnt_reg : lo_cnt_reg;
    assign total       = TOT_W'(hi_cnt_reg) + TOT_W'(lo_cnt_reg);
    assign total_after = total - TOT_W'(1);
    assign bytes_after = byte_total_reg - BT_W'(rd_bytes);
    assign over_after  = cfg.byte_mode ? (BC_W'(bytes_after) > BC_W'(limit_bytes))
                                       : (PC_W'(total_after) > PC_W'(cfg.queue_limit));
    assign out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.op          = op_reg;
        stat.arr_high    = hi_reg;
        stat.arr_over    = cfg.byte_mode
            ? (BC_W'(byte_total_reg) + BC_W'(bytes_reg) >= BC_W'(limit_bytes))
            : (PC_W'(total) + PC_W'(1) >= PC_W'(cfg.queue_limit));
        stat.arr_full    = (arr_cnt == DEPTH_C);
        stat.arr_empty   = (arr_cnt == '0);
        stat.deq_high    = cfg.two_queue_enable && (hi_cnt_reg != '0);
        stat.lo_nonempty = (lo_cnt_reg != '0);
        stat.shrink_go   = (total != '0) && (cfg.byte_mode
            ? (BC_W'(byte_total_reg) > BC_W'(limit_bytes))
            : (PC_W'(total) > PC_W'(cfg.queue_limit)));
        stat.shrink_last = (drop_cnt_reg == NCNT_W'(MAX_RESULTS - 1)) || !over_after
                           || (total_after == '0);
        stat.drop_front  = cfg.drop_front;
        stat.out_free    = out_free;
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            tag_reg   <= packet_tag;
            bytes_reg <= packet_bytes;
            hi_reg    <= cfg.two_queue_enable && (is_ack == PT_ACK);
        end
        if (cmd.rd)
        begin
            rd_high_reg <= cmd.rd_high;
            rd_tail_reg <= cmd.rd_tail;
        end
    end

    // pointer, count and byte total update
    always_comb
    begin
        hi_head_next    = hi_head_reg;
        lo_head_next    = lo_head_reg;
        hi_cnt_next     = hi_cnt_reg;
        lo_cnt_next     = lo_cnt_reg;
        byte_total_next = byte_total_reg;
        drop_cnt_next   = drop_cnt_reg;
        if (cmd.push)
        begin
            byte_total_next = byte_total_next + BT_W'(bytes_reg);
            if (hi_reg)
            begin
                hi_cnt_next = hi_cnt_next + CNT_W'(1);
            end
            else
            begin
                lo_cnt_next = lo_cnt_next + CNT_W'(1);
            end
        end
        if (cmd.pop)
        begin
            byte_total_next = byte_total_next - BT_W'(rd_bytes);
            drop_cnt_next   = drop_cnt_reg + NCNT_W'(1);
            if (rd_high_reg)
            begin
                hi_cnt_next = hi_cnt_next - CNT_W'(1);
                if (!rd_tail_reg)
                begin
                    hi_head_next = wrap((PTR_W + 1)'(hi_head_reg) + (PTR_W + 1)'(1));
                end
            end
            else
            begin
                lo_cnt_next = lo_cnt_next - CNT_W'(1);
                if (!rd_tail_reg)
                begin
                    lo_head_next = wrap((PTR_W + 1)'(lo_head_reg) + (PTR_W + 1)'(1));
                end
            end
        end
        if (cmd.load)
        begin
            drop_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_head_reg    <= '0;
            lo_head_reg    <= '0;
            hi_cnt_reg     <= '0;
            lo_cnt_reg     <= '0;
            byte_total_reg <= '0;
            drop_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hi_head_reg    <= hi_head_next;
            lo_head_reg    <= lo_head_next;
            hi_cnt_reg     <= hi_cnt_next;
            lo_cnt_reg     <= lo_cnt_next;
            byte_total_reg <= byte_total_next;
            drop_cnt_reg   <= drop_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result beat register
    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg  <= cmd.kind;
            olast_reg <= cmd.last;
            if (cmd.use_rd)
            begin
                otag_reg   <= rd_entry[ENT_W-1:BYTES_W];
                obytes_reg <= rd_bytes;
                ohigh_reg  <= rd_high_reg;
            end
            else if (cmd.kind == KIND_NONE)
            begin
                otag_reg   <= '0;
                obytes_reg <= '0;
                ohigh_reg  <= 1'b0;
            end
            else
            begin
                otag_reg   <= tag_reg;
                obytes_reg <= bytes_reg;
                ohigh_reg  <= hi_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_tag     = otag_reg;
    assign out_bytes   = obytes_reg;
    assign from_high   = ohigh_reg;
    assign last        = olast_reg;

    // occupancy stays within the store
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hi_cnt_reg <= DEPTH_C) && (lo_cnt_reg <= DEPTH_C))
        else $error("FIFO count beyond depth");

    // a plain append only goes into a FIFO with room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && !cmd.pop |=> (hi_reg ? hi_cnt_reg : lo_cnt_reg) != '0)
        else $error("append lost");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && !cmd.pop |-> !stat.arr_full)
        else $error("append into a full FIFO");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpq_pkg::*;

    localparam int DEPTH     = DEF_QUEUE_DEPTH;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 8;
    localparam int LO_Q      = 0;
    localparam int HI_Q      = 1;

    // opcode the block does not define; it must answer with a kind-0 beat
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // packet size profiles for random traffic
    localparam int LEN_WIDE = 0;
    localparam int LEN_TINY = 1;
    localparam int LEN_ZERO = 2;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [TAG_WIDTH-1:0] tag;
        logic [BYTES_W-1:0]   len;
        logic                 ack;
        int                   gap;
    } pkt_cmd_t;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [TAG_WIDTH-1:0] tag;
        logic [BYTES_W-1:0]   len;
        logic                 high;
        logic                 is_last;
    } pkt_res_t;

    typedef struct {
        logic [TAG_WIDTH-1:0] tag;
        logic [BYTES_W-1:0]   len;
    } desc_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode       = '0;
    logic [TAG_WIDTH-1:0] packet_tag   = '0;
    logic [BYTES_W-1:0]   packet_bytes = '0;
    logic                 is_ack       = 1'b0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [KIND_W-1:0]    result_kind;
    logic [TAG_WIDTH-1:0] out_tag;
    logic [BYTES_W-1:0]   out_bytes;
    logic                 from_high;
    logic                 last;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_DAT_W-1:0] cfg_data     = '0;

    // shadow of the queue manager
    cfg_t            shadow_cfg;
    desc_t           fifo_mem [2][DEPTH];
    int              fifo_head [2] = '{0, 0};
    int              fifo_cnt  [2] = '{0, 0};
    longint unsigned bytes_queued  = 0;

    pkt_res_t expected_results[$];
    pkt_cmd_t pending_cmds[$];
    int       err_count = 0;

    // sender state
    pkt_cmd_t cur_cmd;
    bit       tx_busy        = 1'b0;
    bit       tx_loaded      = 1'b0;
    int       tx_wait        = 0;
    bit       sender_gaps_on = 1'b1;
    int       queued_total   = 0;

    // receiver state
    int       rx_wait          = 0;
    bit       receiver_gaps_on = 1'b1;
    int       seen_results     = 0;
    int       hold_seq         = 0;
    int       hold_seen        = 0;
    int       hold_left        = 0;

    always #6 clk = ~clk;

    two_class_priority_drop_tail_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .packet_tag  (packet_tag),
        .packet_bytes(packet_bytes),
        .is_ack      (is_ack),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_tag     (out_tag),
        .out_bytes   (out_bytes),
        .from_high   (from_high),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // shadow FIFO helpers
    function automatic void fifo_push(int q, desc_t d);
        fifo_mem[q][(fifo_head[q] + fifo_cnt[q]) % DEPTH] = d;
        fifo_cnt[q]++;
        bytes_queued += d.len;
    endfunction

    function automatic desc_t fifo_take(int q, bit from_tail);
        desc_t d;
        if (from_tail)
        begin
            d = fifo_mem[q][(fifo_head[q] + fifo_cnt[q] - 1) % DEPTH];
        end
        else
        begin
            d = fifo_mem[q][fifo_head[q]];
            fifo_head[q] = (fifo_head[q] + 1) % DEPTH;
        end
        fifo_cnt[q]--;
        bytes_queued -= d.len;
        return d;
    endfunction

    function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_TWO_QUEUE:  shadow_cfg.two_queue_enable = val[0];
            REG_BYTE_MODE:  shadow_cfg.byte_mode        = val[0];
            REG_DROP_FRONT: shadow_cfg.drop_front       = val[0];
            REG_QLIMIT:     shadow_cfg.queue_limit      = val[QLIM_W-1:0];
            REG_MEAN_SIZE:  shadow_cfg.mean_packet_size = val;
            default: ;
        endcase
    endfunction

    // work out the beats one command causes and queue them in order
    function automatic void predict_results(pkt_cmd_t c);
        pkt_res_t        res[$];
        pkt_res_t        r;
        pkt_res_t        none_res;
        desc_t           arr;
        desc_t           d;
        longint unsigned limit_bytes;
        longint unsigned total;
        bit              hi;
        bit              over;
        int              q;

        limit_bytes = 64'(shadow_cfg.queue_limit) * 64'(shadow_cfg.mean_packet_size);
        total       = fifo_cnt[LO_Q] + fifo_cnt[HI_Q];
        arr         = '{c.tag, c.len};
        none_res    = '{KIND_NONE, '0, '0, 1'b0, 1'b0};
        r           = none_res;

        case (c.op)
            OP_ENQ:
            begin
                hi   = shadow_cfg.two_queue_enable && (c.ack == PT_ACK);
                q    = hi ? HI_Q : LO_Q;
                over = shadow_cfg.byte_mode ? (bytes_queued + c.len >= limit_bytes)
                                            : (total + 1 >= shadow_cfg.queue_limit);
                r    = '{KIND_DROP, c.tag, c.len, hi, 1'b0};
                if (over && shadow_cfg.drop_front)
                begin
                    // head drop: arrival takes the freed place
                    if (fifo_cnt[q] > 0)
                    begin
                        d = fifo_take(q, 1'b0);
                        fifo_push(q, arr);
                        r.tag = d.tag;
                        r.len = d.len;
                    end
                end
                else if (!over && fifo_cnt[q] < DEPTH)
                begin
                    fifo_push(q, arr);
                    r.kind = KIND_ACCEPT;
                end
                res.push_back(r);
            end
            OP_DEQ:
            begin
                if (shadow_cfg.two_queue_enable && fifo_cnt[HI_Q] > 0)
                begin
                    d = fifo_take(HI_Q, 1'b0);
                    r = '{KIND_DELIVER, d.tag, d.len, 1'b1, 1'b0};
                end
                else if (fifo_cnt[LO_Q] > 0)
                begin
                    d = fifo_take(LO_Q, 1'b0);
                    r = '{KIND_DELIVER, d.tag, d.len, 1'b0, 1'b0};
                end
                res.push_back(r);
            end
            OP_SHRINK:
            begin
                // low queue goes first, high only once low is empty
                while (res.size() < MAX_RESULTS)
                begin
                    total = fifo_cnt[LO_Q] + fifo_cnt[HI_Q];
                    over  = shadow_cfg.byte_mode ? (bytes_queued > limit_bytes)
                                                 : (total > shadow_cfg.queue_limit);
                    if (!over || total == 0)
                        break;
                    q = (fifo_cnt[LO_Q] > 0) ? LO_Q : HI_Q;
                    d = fifo_take(q, !shadow_cfg.drop_front);
                    r = '{KIND_DROP, d.tag, d.len, (q == HI_Q), 1'b0};
                    res.push_back(r);
                end
                if (res.size() == 0)
                    res.push_back(none_res);
            end
            default:
                res.push_back(none_res);
        endcase

        res[res.size() - 1].is_last = 1'b1;
        foreach (res[i])
            expected_results.push_back(res[i]);
    endfunction

    // sender: one beat per command, idle cycles drawn per command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_results(cur_cmd);
                tx_busy = 1'b0;
            end
            if (!tx_busy && !tx_loaded && pending_cmds.size() > 0)
            begin
                cur_cmd   = pending_cmds.pop_front();
                tx_wait   = cur_cmd.gap;
                tx_loaded = 1'b1;
            end
            if (!tx_busy && tx_loaded)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                end
                else
                begin
                    tx_busy      = 1'b1;
                    tx_loaded    = 1'b0;
                    opcode       <= cur_cmd.op;
                    packet_tag   <= cur_cmd.tag;
                    packet_bytes <= cur_cmd.len;
                    is_ack       <= cur_cmd.ack;
                end
            end
            in_valid <= tx_busy;
        end
    end

    // receiver: check each beat against the oldest expectation, then pick a stall
    always @(posedge clk)
    begin : rx_side
        pkt_res_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat kind %0d tag %h bytes %h",
                                              result_kind, out_tag, out_bytes));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch($sformatf("result_kind %0d, want %0d",
                                                  result_kind, want.kind));
                    if (out_tag !== want.tag)
                        report_mismatch($sformatf("out_tag %h, want %h", out_tag, want.tag));
                    if (out_bytes !== want.len)
                        report_mismatch($sformatf("out_bytes %h, want %h", out_bytes, want.len));
                    if (from_high !== want.high)
                        report_mismatch($sformatf("from_high %b, want %b", from_high, want.high));
                    if (last !== want.is_last)
                        report_mismatch($sformatf("last %b, want %b", last, want.is_last));
                end
                seen_results++;
                if (seen_results % 40 == 0)
                    receiver_gaps_on = ($urandom_range(0, 2) != 0);
                rx_wait = receiver_gaps_on ? $urandom_range(0, 8) : 0;
            end
            // long back-pressure window requested by the stimulus
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_cmd(logic [OP_W-1:0] op, logic [TAG_WIDTH-1:0] tag,
                             logic [BYTES_W-1:0] len, logic ack);
        pkt_cmd_t c;
        if (queued_total % 30 == 0)
            sender_gaps_on = ($urandom_range(0, 2) != 0);
        queued_total++;
        c.op  = op;
        c.tag = tag;
        c.len = len;
        c.ack = ack;
        c.gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_write(idx, val);
    endtask

    // unused upper data bits carry noise
    task automatic program_regs(bit two_q, bit bm, bit df, int lim, int mean);
        write_reg(REG_TWO_QUEUE,  {15'($urandom), two_q});
        write_reg(REG_BYTE_MODE,  {15'($urandom), bm});
        write_reg(REG_DROP_FRONT, {15'($urandom), df});
        write_reg(REG_QLIMIT,     {9'($urandom), 7'(lim)});
        write_reg(REG_MEAN_SIZE,  16'(mean));
    endtask

    // wait for the sender to run dry and every beat to come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tx_busy || tx_loaded || pending_cmds.size() != 0 ||
               expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_burst(int n, int enq_pct, int deq_pct, int len_style);
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [BYTES_W-1:0] len;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < enq_pct)
                op = OP_ENQ;
            else if (pick < enq_pct + deq_pct)
                op = OP_DEQ;
            else if (pick < 98)
                op = OP_SHRINK;
            else
                op = OP_UNUSED;
            case (len_style)
                LEN_TINY: len = 16'($urandom_range(1, 15));
                LEN_ZERO: len = ($urandom_range(0, 3) != 0) ? '0 : 16'($urandom);
                default:
                begin
                    pick = $urandom_range(0, 9);
                    len  = (pick == 0) ? '0 : (pick == 1) ? '1 : 16'($urandom);
                end
            endcase
            queue_cmd(op, 16'($urandom), len, 1'($urandom));
        end
    endtask

    task automatic run_phase(input bit two_q, input bit bm, input bit df, input int lim,
                             input int mean, input int n, input int enq_pct,
                             input int deq_pct, input int len_style, input bit with_hold);
        program_regs(two_q, bm, df, lim, mean);
        random_burst(n, enq_pct, deq_pct, len_style);
        if (with_hold)
            hold_seq++;
        wait_drained();
    endtask

    initial
    begin : stimulus
        shadow_cfg = '{RST_TWO_QUEUE, RST_BYTE_MODE, RST_DROP_FRONT, RST_QLIMIT, RST_MEAN_SIZE};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty cases, unused opcode, field extremes, priority order
        queue_cmd(OP_DEQ,    16'h0000, 16'h0000, 1'b0);
        queue_cmd(OP_SHRINK, 16'h0000, 16'h0000, 1'b0);
        queue_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_cmd(OP_ENQ,    16'hFFFF, 16'hFFFF, PT_ACK);
        queue_cmd(OP_ENQ,    16'h0000, 16'h0000, 1'b0);
        queue_cmd(OP_ENQ,    16'hA5A5, 16'h5A5A, 1'b0);
        queue_cmd(OP_ENQ,    16'h5A5A, 16'hA5A5, PT_ACK);
        repeat (5) queue_cmd(OP_DEQ, 16'h0000, 16'h0000, 1'b0);
        wait_drained();

        // zero limit: every arrival overflows, drop-front on empty FIFO drops arrival
        program_regs(1, 0, 1, 0, 500);
        queue_cmd(OP_ENQ, 16'h1234, 16'd100, 1'b0);
        queue_cmd(OP_ENQ, 16'h4321, 16'd200, PT_ACK);
        wait_drained();

        // packet limit 3: third arrival and the ack overflow
        program_regs(1, 0, 0, 3, 1);
        repeat (3) queue_cmd(OP_ENQ, 16'($urandom), 16'($urandom), 1'b0);
        queue_cmd(OP_ENQ,    16'hBEEF, 16'h0101, PT_ACK);
        queue_cmd(OP_SHRINK, 16'h0000, 16'h0000, 1'b0);
        wait_drained();

        // drop-front overflow and a head-dropping shrink
        program_regs(1, 0, 1, 1, 1);
        queue_cmd(OP_ENQ,    16'hCAFE, 16'h0202, 1'b0);
        queue_cmd(OP_SHRINK, 16'h0000, 16'h0000, 1'b0);
        wait_drained();

        program_regs(1, 0, 0, 64, 1);
        queue_cmd(OP_ENQ, 16'h0AC1, 16'h0040, PT_ACK);
        queue_cmd(OP_ENQ, 16'h0AC2, 16'h0041, PT_ACK);
        wait_drained();

        // single queue: dequeue skips the high FIFO, shrink falls back to it
        program_regs(0, 0, 0, 1, 1);
        queue_cmd(OP_DEQ,    16'h0000, 16'h0000, 1'b0);
        queue_cmd(OP_SHRINK, 16'h0000, 16'h0000, 1'b0);
        queue_cmd(OP_ENQ,    16'h0AC3, 16'h0042, PT_ACK);
        wait_drained();

        // random traffic under a series of settings
        run_phase(1, 0, 0, 50, 500,   40, 50, 40, LEN_WIDE, 1);
        run_phase(1, 0, 1, 8,  500,   35, 60, 30, LEN_WIDE, 0);
        run_phase(0, 0, 0, 64, 65535, 35, 55, 35, LEN_WIDE, 0);
        run_phase(1, 1, 0, 4,  65535, 35, 60, 30, LEN_WIDE, 0);
        run_phase(1, 1, 1, 1,  1,     35, 65, 25, LEN_ZERO, 0);
        // fill both FIFOs past their physical depth
        run_phase(1, 1, 0, 64, 65535, 140, 92, 5, LEN_TINY, 0);

        // deep shrink: more drops than one command may take
        program_regs(0, 0, 1, 1, 1);
        queue_cmd(OP_SHRINK, 16'h0000, 16'h0000, 1'b0);
        queue_cmd(OP_SHRINK, 16'h0000, 16'h0000, 1'b0);
        random_burst(30, 40, 30, LEN_WIDE);
        wait_drained();

        run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)),
                  $urandom_range(0, 64), $urandom_range(1, 65535), 20, 55, 30, LEN_WIDE, 0);
        run_phase(1, 0, 0, 1, 500, 15, 60, 30, LEN_WIDE, 0);
        run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)),
                  $urandom_range(0, 64), $urandom_range(1, 65535), 15, 60, 25, LEN_TINY, 0);

        repeat (SETTLE) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit far above the slowest legal run
    initial
    begin : watchdog
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tcpq_pkg.sv
hdl/tcpq_ctrl.sv
hdl/tcpq_datapath.sv
hdl/two_class_priority_drop_tail_queue_unit.sv
dv/tb_top.sv
